// File: rtl/itt_pkg.sv
// Types and constants of the interval task timer table.
`default_nettype none
package itt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NFIRE_W     = 5;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_EXEC = 2'd2;

  typedef struct packed {
    logic        lane;
    logic [7:0]  handle;
    logic [31:0] interval;
    logic [31:0] last_time;
    logic        one_shot;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage
`default_nettype wire

// File: rtl/interval_task_timer_table_core.sv
// Interval task timer table: task memory, add path and execute walk with compaction.
//
// An add leaves busy low and its single result word appears on the cycle after start.
// An execute raises busy while the task memory is read once per stored entry;
// fired-task words come out in table order during the walk and the word marked last
// comes out as busy falls. One-shot tasks that fire are dropped and the table is
// compacted in the same pass. Result words are strobed by out_valid for one cycle
// each and cannot be held off.
`default_nettype none
module interval_task_timer_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_command,
  input  wire  [31:0] in_now_ms,
  input  wire         in_lane,
  input  wire  [7:0]  in_handle,
  input  wire  [31:0] in_interval_ms,
  input  wire         in_one_shot,
  output logic        out_valid,
  output logic        out_fired,
  output logic [7:0]  out_fired_handle,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_halted
);
  import itt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     wr_r, wr_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [NFIRE_W-1:0] nfire_r, nfire_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [7:0]        pend_handle_r, pend_handle_nxt;
  logic              lane_r, lane_nxt;
  logic [31:0]       now_r, now_nxt;
  logic              halted_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_fired_r, out_fired_nxt;
  logic [7:0]        out_handle_r, out_handle_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              fire;
  logic [31:0]       elapsed;

  assign busy             = (state_r == ST_WALK);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_fired_handle = out_handle_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  assign elapsed = now_r - rdata_r.last_time;
  assign fire    = !halted_r && (rdata_r.lane == lane_r) && (elapsed >= rdata_r.interval) &&
                   (nfire_r < NFIRE_W'(MAX_RESULTS));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    rvalid_nxt      = 1'b0;
    nfire_nxt       = nfire_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;
    lane_nxt        = lane_r;
    now_nxt         = now_r;
    out_valid_nxt   = 1'b0;
    out_fired_nxt   = 1'b0;
    out_handle_nxt  = 8'd0;
    out_status_nxt  = STATUS_OK;
    out_last_nxt    = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = wr_r[AW-1:0];
    mem_wdata       = rdata_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_ADD) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            if (count_r == CW'(TABLE_DEPTH)) begin
              out_status_nxt = STATUS_FULL;
            end else begin
              out_status_nxt      = STATUS_OK;
              mem_we              = 1'b1;
              mem_waddr           = count_r[AW-1:0];
              mem_wdata.lane      = in_lane;
              mem_wdata.handle    = in_handle;
              mem_wdata.interval  = in_interval_ms;
              mem_wdata.last_time = in_now_ms;
              mem_wdata.one_shot  = in_one_shot;
              count_nxt           = count_r + CW'(1);
            end
          end else begin
            state_nxt      = ST_WALK;
            lane_nxt       = in_lane;
            now_nxt        = in_now_ms;
            rd_nxt         = '0;
            wr_nxt         = '0;
            nfire_nxt      = '0;
            pend_valid_nxt = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (rd_r < count_r) begin
          rd_nxt     = rd_r + CW'(1);
          rvalid_nxt = 1'b1;
        end
        if (rvalid_r) begin
          if (fire) begin
            nfire_nxt       = nfire_r + NFIRE_W'(1);
            pend_valid_nxt  = 1'b1;
            pend_handle_nxt = rdata_r.handle;
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_fired_nxt  = 1'b1;
              out_handle_nxt = pend_handle_r;
              out_status_nxt = STATUS_EXEC;
            end
          end
          if (!(fire && rdata_r.one_shot)) begin
            mem_we    = 1'b1;
            mem_waddr = wr_r[AW-1:0];
            if (fire) begin
              mem_wdata.last_time = now_r;
            end
            wr_nxt = wr_r + CW'(1);
          end
        end else if (rd_r == count_r) begin
          count_nxt      = wr_r;
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = pend_valid_r;
          out_handle_nxt = pend_valid_r ? pend_handle_r : 8'd0;
          out_status_nxt = STATUS_EXEC;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rvalid_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      halted_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rvalid_r     <= rvalid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        halted_r <= cfg_halted;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r          <= rd_nxt;
    wr_r          <= wr_nxt;
    nfire_r       <= nfire_nxt;
    pend_handle_r <= pend_handle_nxt;
    lane_r        <= lane_nxt;
    now_r         <= now_nxt;
    out_fired_r   <= out_fired_nxt;
    out_handle_r  <= out_handle_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule
`default_nettype wire
